>>> rtl/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/aso_pkg.sv
package aso_pkg;

  localparam int unsigned Q_BITS    = 48;
  localparam int unsigned NUM_W     = 104;
  localparam int unsigned DEN_W     = 86;
  localparam int unsigned DIV_LAT   = Q_BITS + 1;
  localparam int unsigned LANE_LAT  = 7 + DIV_LAT;
  localparam int unsigned PIPE_DEPTH = 2 + LANE_LAT;
  localparam int unsigned NUM_COLS  = 7;

  localparam logic [1:0]  LAST_ROW  = 2'd3;
  localparam logic [31:0] ONE16     = 32'd65536;
  localparam logic signed [15:0] TRIG_ONE = 16'sd16384;
  localparam logic [47:0] VAL_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] VAL_MIN   = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    TRIG_NONE,
    TRIG_COS,
    TRIG_SIN
  } trig_t;

  typedef enum logic [1:0] {
    DEN_R,
    DEN_L,
    DEN_LL,
    DEN_LR
  } den_t;

  typedef struct packed {
    logic              present;
    logic signed [4:0] k0;
    logic signed [4:0] k1;
    logic signed [4:0] k2;
    logic signed [4:0] k3;
    trig_t             trig;
    logic              by_len;
    den_t              den;
  } term_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         row;
    logic [16:0]        x;
    logic [31:0]        r;
    logic [31:0]        len;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } row_req_t;

  typedef struct packed {
    logic [1:0]         row;
    logic [16:0]        x;
    logic [33:0]        x2;
    logic [50:0]        x3;
    logic [31:0]        r;
    logic [31:0]        len;
    logic [63:0]        dll;
    logic [63:0]        dlr;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } row_ops_t;

  function automatic term_t mk(input logic signed [4:0] k0, input logic signed [4:0] k1,
                               input logic signed [4:0] k2, input logic signed [4:0] k3,
                               input trig_t tg, input logic bl, input den_t dn);
    term_t t;
    t = '{present: 1'b1, k0: k0, k1: k1, k2: k2, k3: k3, trig: tg, by_len: bl, den: dn};
    return t;
  endfunction

  function automatic term_t term_of(input logic [1:0] row, input logic [2:0] col);
    term_t t;
    t = '{present: 1'b0, k0: 5'sd0, k1: 5'sd0, k2: 5'sd0, k3: 5'sd0,
          trig: TRIG_NONE, by_len: 1'b0, den: DEN_R};
    unique case ({row, col})
      {2'd0, 3'd0}: t = mk(-5'sd3, 5'sd4, 5'sd0, 5'sd0, TRIG_NONE, 1'b0, DEN_L);
      {2'd0, 3'd3}: t = mk(-5'sd1, 5'sd4, 5'sd0, 5'sd0, TRIG_NONE, 1'b0, DEN_L);
      {2'd0, 3'd6}: t = mk(5'sd4, -5'sd8, 5'sd0, 5'sd0, TRIG_NONE, 1'b0, DEN_L);
      {2'd1, 3'd0}: t = mk(5'sd1, -5'sd3, 5'sd2, 5'sd0, TRIG_COS, 1'b0, DEN_R);
      {2'd1, 3'd1}: t = mk(5'sd1, 5'sd0, -5'sd3, 5'sd2, TRIG_SIN, 1'b0, DEN_R);
      {2'd1, 3'd2}: t = mk(5'sd0, 5'sd1, -5'sd2, 5'sd1, TRIG_SIN, 1'b1, DEN_R);
      {2'd1, 3'd3}: t = mk(5'sd0, -5'sd1, 5'sd2, 5'sd0, TRIG_COS, 1'b0, DEN_R);
      {2'd1, 3'd4}: t = mk(5'sd0, 5'sd0, 5'sd3, -5'sd2, TRIG_SIN, 1'b0, DEN_R);
      {2'd1, 3'd5}: t = mk(5'sd0, 5'sd0, -5'sd1, 5'sd1, TRIG_SIN, 1'b1, DEN_R);
      {2'd1, 3'd6}: t = mk(5'sd0, 5'sd4, -5'sd4, 5'sd0, TRIG_COS, 1'b0, DEN_R);
      {2'd2, 3'd1}: t = mk(-5'sd6, 5'sd12, 5'sd0, 5'sd0, TRIG_NONE, 1'b0, DEN_LL);
      {2'd2, 3'd2}: t = mk(-5'sd4, 5'sd6, 5'sd0, 5'sd0, TRIG_NONE, 1'b0, DEN_L);
      {2'd2, 3'd4}: t = mk(5'sd6, -5'sd12, 5'sd0, 5'sd0, TRIG_NONE, 1'b0, DEN_LL);
      {2'd2, 3'd5}: t = mk(-5'sd2, 5'sd6, 5'sd0, 5'sd0, TRIG_NONE, 1'b0, DEN_L);
      {2'd3, 3'd1}: t = mk(5'sd0, -5'sd6, 5'sd6, 5'sd0, TRIG_COS, 1'b0, DEN_LR);
      {2'd3, 3'd2}: t = mk(5'sd1, -5'sd4, 5'sd3, 5'sd0, TRIG_COS, 1'b0, DEN_R);
      {2'd3, 3'd4}: t = mk(5'sd0, 5'sd6, -5'sd6, 5'sd0, TRIG_COS, 1'b0, DEN_LR);
      {2'd3, 3'd5}: t = mk(5'sd0, -5'sd2, 5'sd3, 5'sd0, TRIG_COS, 1'b0, DEN_R);
      default: ;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/aso_point_if.sv
interface aso_point_if;
  logic               valid;
  logic               ready;
  logic [16:0]        coord_xsi;
  logic [31:0]        radius;
  logic [31:0]        elem_length;
  logic signed [15:0] cos_angle;
  logic signed [15:0] sin_angle;

  modport source (output valid, coord_xsi, radius, elem_length, cos_angle, sin_angle,
                  input ready);
  modport sink (input valid, coord_xsi, radius, elem_length, cos_angle, sin_angle,
                output ready);
endinterface

>>> rtl/aso_row_if.sv
interface aso_row_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [47:0] col0_value;
  logic signed [47:0] col1_value;
  logic signed [47:0] col2_value;
  logic signed [47:0] col3_value;
  logic signed [47:0] col4_value;
  logic signed [47:0] col5_value;
  logic signed [47:0] col6_value;
  logic               saturated;
  logic               last_row;

  modport source (output valid, row_index, col0_value, col1_value, col2_value, col3_value,
                  col4_value, col5_value, col6_value, saturated, last_row,
                  input ready);
  modport sink (input valid, row_index, col0_value, col1_value, col2_value, col3_value,
                col4_value, col5_value, col6_value, saturated, last_row,
                output ready);
endinterface

>>> rtl/axisym_shell_strain_operator.sv
// The row sequencer feeds the four rows of an item one a cycle, while the output is
// not stalled, into seven lanes, each with a 49-stage divider that resolves one
// quotient bit per stage after its input stage. A new item is taken as the last row
// of the one before issues. Each row passes s1 and s2, its lane and the output register.
// Reset (rst, synchronous): clears the sequencer, the valid pipe and the output
// valid register; data registers are not reset.
`include "assert_macros.svh"

module axisym_shell_strain_operator (
  input  logic        clk,
  input  logic        rst,
  aso_point_if.sink   point,
  aso_row_if.source   strain
);

  localparam int unsigned PD = aso_pkg::PIPE_DEPTH;
  localparam int unsigned NC = aso_pkg::NUM_COLS;

  aso_pkg::row_req_t  req;
  aso_pkg::row_ops_t  s1;
  aso_pkg::row_ops_t  s2;
  logic               adv;
  logic [PD-1:0]      vld;
  logic [1:0]         rows [0:PD-1];

  logic signed [47:0] lval [0:NC-1];
  logic [NC-1:0]      lsat;

  logic               ovalid;
  logic [1:0]         orow;
  logic signed [47:0] ocol [0:NC-1];
  logic               osat;
  logic               at_lim;

  assign adv = !(ovalid && !strain.ready);

  aso_issue u_issue (
    .clk   (clk),
    .rst   (rst),
    .point (point),
    .adv   (adv),
    .req   (req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PD-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rows[0] <= req.row;
      for (int i = 1; i < PD; i++) begin
        rows[i] <= rows[i-1];
      end

      s1.row <= req.row;
      s1.x   <= req.x;
      s1.x2  <= 34'(req.x) * 34'(req.x);
      s1.x3  <= '0;
      s1.r   <= req.r;
      s1.len <= req.len;
      s1.dll <= 64'(req.len) * 64'(req.len);
      s1.dlr <= 64'(req.len) * 64'(req.r);
      s1.cs  <= req.cs;
      s1.sn  <= req.sn;

      s2.row <= s1.row;
      s2.x   <= s1.x;
      s2.x2  <= s1.x2;
      s2.x3  <= 51'(s1.x2) * 51'(s1.x);
      s2.r   <= s1.r;
      s2.len <= s1.len;
      s2.dll <= s1.dll;
      s2.dlr <= s1.dlr;
      s2.cs  <= s1.cs;
      s2.sn  <= s1.sn;
    end
  end

  for (genvar c = 0; c < NC; c++) begin : g_lane
    aso_lane u_lane (
      .clk (clk),
      .adv (adv),
      .col (3'(c)),
      .ops (s2),
      .val (lval[c]),
      .sat (lsat[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (adv) begin
      ovalid <= vld[PD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      orow <= rows[PD-1];
      osat <= |lsat;
      for (int c = 0; c < NC; c++) begin
        ocol[c] <= lval[c];
      end
    end
  end

  assign strain.valid      = ovalid;
  assign strain.row_index  = orow;
  assign strain.col0_value = ocol[0];
  assign strain.col1_value = ocol[1];
  assign strain.col2_value = ocol[2];
  assign strain.col3_value = ocol[3];
  assign strain.col4_value = ocol[4];
  assign strain.col5_value = ocol[5];
  assign strain.col6_value = ocol[6];
  assign strain.saturated  = osat;
  assign strain.last_row   = orow == aso_pkg::LAST_ROW;

  always_comb begin
    at_lim = 1'b0;
    for (int c = 0; c < NC; c++) begin
      if (ocol[c] == aso_pkg::VAL_MAX || ocol[c] == aso_pkg::VAL_MIN) begin
        at_lim = 1'b1;
      end
    end
  end

  `ASSERT_IMPL(a_sat_has_clip, strain.valid && strain.saturated, at_lim)
  `ASSERT_NEXT(a_row_follows, strain.valid && strain.ready && vld[PD-1],
               strain.valid && strain.row_index == $past(rows[PD-1]))

endmodule

>>> rtl/aso_issue.sv
`include "assert_macros.svh"

module aso_issue (
  input  logic              clk,
  input  logic              rst,
  aso_point_if.sink         point,
  input  logic              adv,
  output aso_pkg::row_req_t req
);

  logic               busy;
  logic [1:0]         cnt;
  logic [16:0]        x;
  logic [31:0]        r;
  logic [31:0]        len;
  logic signed [15:0] cs;
  logic signed [15:0] sn;
  logic               take;

  assign point.ready = !busy || (cnt == aso_pkg::LAST_ROW && adv);
  assign take        = point.valid && point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
    end else if (busy && adv) begin
      if (cnt == aso_pkg::LAST_ROW) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x   <= point.coord_xsi;
      r   <= point.radius;
      len <= point.elem_length;
      cs  <= point.cos_angle;
      sn  <= point.sin_angle;
    end
  end

  assign req = '{valid: busy, row: cnt, x: x, r: r, len: len, cs: cs, sn: sn};

  `ASSERT_NEXT(a_take_starts_row0, take, busy && cnt == 2'd0)
  `ASSERT_NEXT(a_rows_in_order, busy && adv && cnt != aso_pkg::LAST_ROW && !take,
               busy && cnt == $past(cnt) + 2'd1)

endmodule

>>> rtl/aso_div.sv
module aso_div (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [aso_pkg::NUM_W-1:0]     num,
  input  logic [aso_pkg::DEN_W-1:0]     den,
  output logic [aso_pkg::Q_BITS-1:0]    quo,
  output logic                          ovf
);

  localparam int unsigned QB = aso_pkg::Q_BITS;
  localparam int unsigned DW = aso_pkg::DEN_W;
  localparam int unsigned NW = aso_pkg::NUM_W;

  logic [DW-1:0] rem [0:QB];
  logic [DW-1:0] dv  [0:QB];
  logic [QB-1:0] low [0:QB];
  logic [QB-1:0] qs  [0:QB];
  logic          of  [0:QB];

  // Quotient of 2^48 or more is flagged up front.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= DW'(num[NW-1:QB]);
      dv[0]  <= den;
      low[0] <= num[QB-1:0];
      qs[0]  <= '0;
      of[0]  <= DW'(num[NW-1:QB]) >= den;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [DW:0] rs;
    logic [DW:0] diff;
    logic        ge;

    assign rs   = {rem[s], low[s][QB-1]};
    assign diff = rs - {1'b0, dv[s]};
    assign ge   = rs >= {1'b0, dv[s]};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s+1] <= ge ? diff[DW-1:0] : rs[DW-1:0];
        dv[s+1]  <= dv[s];
        low[s+1] <= {low[s][QB-2:0], 1'b0};
        qs[s+1]  <= {qs[s][QB-2:0], ge};
        of[s+1]  <= of[s];
      end
    end
  end

  assign quo = qs[QB];
  assign ovf = of[QB];

endmodule

>>> rtl/aso_lane.sv
module aso_lane (
  input  logic               clk,
  input  logic               adv,
  input  logic [2:0]         col,
  input  aso_pkg::row_ops_t  ops,
  output logic signed [47:0] val,
  output logic               sat
);

  localparam int unsigned DL = aso_pkg::DIV_LAT;

  aso_pkg::term_t      t;
  logic signed [17:0]  sx;
  logic signed [34:0]  sx2;
  logic signed [51:0]  sx3;
  logic signed [57:0]  p_c;
  logic signed [15:0]  tr_c;
  logic [63:0]         d_c;

  logic signed [57:0]  p1;
  logic signed [15:0]  tr1;
  logic [63:0]         d1;
  logic                wide1;
  logic                bylen1;
  logic [31:0]         len1;

  logic signed [16:0]  trx;
  logic [55:0]         pm2;
  logic [15:0]         tm2;
  logic                neg2;
  logic [31:0]         mm2;
  logic [85:0]         dd2;

  logic [71:0]         a3;
  logic [31:0]         mm3;
  logic [85:0]         dd3;
  logic                neg3;

  logic [67:0]         pl4;
  logic [67:0]         ph4;
  logic [85:0]         dd4;
  logic                neg4;

  logic [103:0]        n5;
  logic [85:0]         dd5;
  logic                neg5;

  logic [103:0]        np6;
  logic [85:0]         dd6;
  logic                neg6;
  logic                nz6;

  logic [47:0]         quo;
  logic                ovf;
  logic [1:0]          side [0:DL-1];

  logic                neg_f;
  logic                nz_f;
  logic [47:0]         lim;
  logic                over;
  logic [47:0]         mag;

  always_comb begin
    t   = aso_pkg::term_of(ops.row, col);
    sx  = $signed({1'b0, ops.x});
    sx2 = $signed({1'b0, ops.x2});
    sx3 = $signed({1'b0, ops.x3});
    p_c = (58'(t.k0) <<< 48) + ((58'(t.k1) * 58'(sx)) <<< 32)
        + ((58'(t.k2) * 58'(sx2)) <<< 16) + 58'(t.k3) * 58'(sx3);
    if (!t.present) begin
      p_c = '0;
    end
    unique case (t.trig)
      aso_pkg::TRIG_COS: tr_c = ops.cs;
      aso_pkg::TRIG_SIN: tr_c = ops.sn;
      default:           tr_c = aso_pkg::TRIG_ONE;
    endcase
    unique case (t.den)
      aso_pkg::DEN_R:  d_c = {32'b0, ops.r};
      aso_pkg::DEN_L:  d_c = {32'b0, ops.len};
      aso_pkg::DEN_LL: d_c = ops.dll;
      aso_pkg::DEN_LR: d_c = ops.dlr;
    endcase
  end

  assign trx = 17'(tr1);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1     <= p_c;
      tr1    <= tr_c;
      d1     <= d_c;
      wide1  <= t.den == aso_pkg::DEN_LL || t.den == aso_pkg::DEN_LR;
      bylen1 <= t.by_len;
      len1   <= ops.len;

      pm2    <= 56'(p1[57] ? -p1 : p1);
      tm2    <= 16'(tr1[15] ? -trx : trx);
      neg2   <= p1[57] ^ tr1[15];
      mm2    <= bylen1 ? len1 : aso_pkg::ONE16;
      // Divisor pre-scaled to the Q23.24 output grid.
      dd2    <= wide1 ? {d1, 22'b0} : {16'b0, d1[31:0], 38'b0};

      a3     <= 72'(pm2) * 72'(tm2);
      mm3    <= mm2;
      dd3    <= dd2;
      neg3   <= neg2;

      pl4    <= 68'(a3[35:0]) * 68'(mm3);
      ph4    <= 68'(a3[71:36]) * 68'(mm3);
      dd4    <= dd3;
      neg4   <= neg3;

      n5     <= 104'(pl4) + (104'(ph4) << 36);
      dd5    <= dd4;
      neg5   <= neg4;

      // Half divisor added for round to nearest.
      np6    <= n5 + 104'(dd5 >> 1);
      nz6    <= |n5;
      dd6    <= dd5;
      neg6   <= neg5;
    end
  end

  aso_div u_div (
    .clk (clk),
    .adv (adv),
    .num (np6),
    .den (dd6),
    .quo (quo),
    .ovf (ovf)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= {neg6, nz6};
      for (int i = 1; i < DL; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  always_comb begin
    neg_f = side[DL-1][1];
    nz_f  = side[DL-1][0];
    lim   = neg_f ? aso_pkg::VAL_MIN : aso_pkg::VAL_MAX;
    over  = ovf || quo > lim;
    mag   = over ? lim : quo;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sat <= nz_f && over;
      if (!nz_f) begin
        val <= '0;
      end else begin
        val <= $signed(neg_f ? -mag : mag);
      end
    end
  end

endmodule
